/* src/sdpa_pkg.sv */
// ============================================================================
// sdpa_pkg: shared types, constants and elaboration-time table functions
// Holds the fixed-point formats, the CORDIC arctangent table and gain, and
// the pi constants used by the sphere distance and position angle core.
// ============================================================================
package sdpa_pkg;

    localparam int FRAC_BITS          = 28;
    localparam int CORDIC_STAGES_DEF  = 30;
    localparam int QI                 = 61;
    localparam int SH                 = QI - FRAC_BITS;
    localparam int MUL_LAT            = 5;
    localparam int ROOT_BITS          = 62;
    localparam int RAD_W              = 2 * ROOT_BITS;

    // Q2.61 working value and a Qf angle with headroom.
    typedef logic signed [63:0] q_t;
    typedef logic signed [33:0] ang_t;

    localparam longint ONE_L = longint'(1) <<< QI;
    localparam q_t     ONE_Q = q_t'(ONE_L);

    // Unsigned quotient by shift and subtract, for the constant tables only.
    function automatic logic [63:0] udiv_c(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Signed Q2.61 product, magnitudes multiplied and truncated toward zero.
    function automatic longint mulq_c(longint a, longint b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [63:0]  r;
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        p  = {64'd0, ua} * {64'd0, ub};
        r  = p[124:61];
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    // arctan(1/n) by its alternating series.
    function automatic longint atan_inv_c(longint n);
        logic [63:0] t;
        logic [63:0] nn;
        logic [63:0] dv;
        longint      sum;
        t   = udiv_c(64'(ONE_L), 64'(n));
        nn  = 64'(n * n);
        sum = longint'(t);
        for (int k = 1; k < 48; k++) begin
            if (t != 64'd0) begin
                t  = udiv_c(t, nn);
                dv = 64'(2 * k + 1);
                if ((k & 1) == 1) sum = sum - longint'(udiv_c(t, dv));
                else              sum = sum + longint'(udiv_c(t, dv));
            end
        end
        return sum;
    endfunction

    // arctan(2^-i) in Q2.61.
    function automatic longint atan_f(int i);
        longint      sum;
        logic [63:0] dv;
        int          sh;
        sum = 0;
        if (i == 0) begin
            sum = 4 * atan_inv_c(5) - atan_inv_c(239);
        end else begin
            for (int k = 0; k < 62; k++) begin
                sh = (2 * k + 1) * i;
                if (sh <= QI) begin
                    dv = 64'(2 * k + 1);
                    if ((k & 1) == 1) sum = sum - longint'(udiv_c(64'(ONE_L) >> sh, dv));
                    else              sum = sum + longint'(udiv_c(64'(ONE_L) >> sh, dv));
                end
            end
        end
        return sum;
    endfunction

    // Reciprocal CORDIC gain for a given stage count.
    function automatic longint gain_f(int stages);
        longint      k2;
        longint      r;
        longint      y;
        longint      t;
        logic [63:0] dv;
        k2 = ONE_L;
        for (int i = 0; i < 64; i++) begin
            if (i < stages) begin
                if (i == 0) begin
                    r = ONE_L >>> 1;
                end else if (2 * i <= 62) begin
                    dv = (64'd1 << (2 * i)) + 64'd1;
                    r  = ONE_L - longint'(udiv_c(64'(ONE_L), dv));
                end else begin
                    r = ONE_L;
                end
                k2 = mulq_c(k2, r);
            end
        end
        y = 0;
        for (int b = QI; b >= 0; b--) begin
            t = y | (longint'(1) <<< b);
            if (mulq_c(t, t) <= k2) y = t;
        end
        return y;
    endfunction

    localparam longint HALF_PI_Q = 2 * atan_f(0);
    localparam ang_t   HALF_PI_F =
        ang_t'((HALF_PI_Q + (longint'(1) <<< (SH - 1))) >>> SH);
    localparam ang_t   PI_F      = ang_t'(2 * HALF_PI_F);
    localparam ang_t   TWO_PI_F  = ang_t'(4 * HALF_PI_F);
    localparam ang_t   FOUR_PI_F = ang_t'(8 * HALF_PI_F);

endpackage

/* src/sdpa_delay.sv */
// ============================================================================
// sdpa_delay: enabled shift line
// Carries side data alongside a pipelined unit so that it lines up again.
// ============================================================================
module sdpa_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [D];

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= d;
            for (int i = 1; i < D; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[D-1];

endmodule

/* src/sdpa_mul.sv */
// ============================================================================
// sdpa_mul: pipelined Q2.61 multiplier
// Sign and magnitude form, four 32x32 partial products, truncation toward zero.
// ============================================================================
module sdpa_mul (
    input  logic          aclk,
    input  logic          en,
    input  sdpa_pkg::q_t  a,
    input  sdpa_pkg::q_t  b,
    output sdpa_pkg::q_t  p
);

    logic [63:0]  ua_reg, ub_reg;
    logic         neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [64:0]  mid_reg;
    logic [63:0]  lo_reg, hi_reg;
    logic [127:0] full_reg;
    sdpa_pkg::q_t p_reg;
    logic [63:0]  mag;

    assign mag = full_reg[124:61];

    always_ff @(posedge aclk) begin
        if (en) begin
            ua_reg   <= a[63] ? 64'(-a) : 64'(a);
            ub_reg   <= b[63] ? 64'(-b) : 64'(b);
            neg1_reg <= a[63] ^ b[63];
            p00_reg  <= 64'(ua_reg[31:0])  * 64'(ub_reg[31:0]);
            p01_reg  <= 64'(ua_reg[31:0])  * 64'(ub_reg[63:32]);
            p10_reg  <= 64'(ua_reg[63:32]) * 64'(ub_reg[31:0]);
            p11_reg  <= 64'(ua_reg[63:32]) * 64'(ub_reg[63:32]);
            neg2_reg <= neg1_reg;
            mid_reg  <= 65'(p01_reg) + 65'(p10_reg);
            lo_reg   <= p00_reg;
            hi_reg   <= p11_reg;
            neg3_reg <= neg2_reg;
            full_reg <= {hi_reg, lo_reg} + {31'd0, mid_reg, 32'd0};
            neg4_reg <= neg3_reg;
            p_reg    <= neg4_reg ? -sdpa_pkg::q_t'(mag) : sdpa_pkg::q_t'(mag);
        end
    end

    assign p = p_reg;

endmodule

/* src/sdpa_cordic_cell.sv */
// ============================================================================
// sdpa_cordic_cell: one CORDIC micro-rotation
// Rotation mode steers on the sign of z, vectoring mode on the sign of y.
// ============================================================================
module sdpa_cordic_cell #(
    parameter int STAGE  = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic         aclk,
    input  logic         en,
    input  sdpa_pkg::q_t x_in,
    input  sdpa_pkg::q_t y_in,
    input  sdpa_pkg::q_t z_in,
    output sdpa_pkg::q_t x_out,
    output sdpa_pkg::q_t y_out,
    output sdpa_pkg::q_t z_out
);

    localparam sdpa_pkg::q_t ATAN = sdpa_pkg::q_t'(sdpa_pkg::atan_f(STAGE));

    sdpa_pkg::q_t x_reg, y_reg, z_reg;
    sdpa_pkg::q_t dx, dy;
    logic         dir, sub_x, add_z;

    always_comb begin
        dx    = y_in >>> STAGE;
        dy    = x_in >>> STAGE;
        dir   = VECTOR ? !y_in[63] : !z_in[63];
        sub_x = VECTOR ? !dir : dir;
        add_z = VECTOR ? dir : !dir;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= sub_x ? x_in - dx : x_in + dx;
            y_reg <= sub_x ? y_in + dy : y_in - dy;
            z_reg <= add_z ? z_in + ATAN : z_in - ATAN;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

/* src/sdpa_sqrt_cell.sv */
// ============================================================================
// sdpa_sqrt_cell: one restoring square-root digit
// Takes the next two radicand bits and settles one root bit.
// ============================================================================
module sdpa_sqrt_cell (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [65:0]                   rem_in,
    input  logic [sdpa_pkg::ROOT_BITS-1:0] root_in,
    input  logic [sdpa_pkg::RAD_W-1:0]     rad_in,
    output logic [65:0]                   rem_out,
    output logic [sdpa_pkg::ROOT_BITS-1:0] root_out,
    output logic [sdpa_pkg::RAD_W-1:0]     rad_out
);

    logic [65:0]                    rem_reg;
    logic [sdpa_pkg::ROOT_BITS-1:0] root_reg;
    logic [sdpa_pkg::RAD_W-1:0]     rad_reg;
    logic [65:0]                    r2, trial;
    logic                           fit;

    always_comb begin
        r2    = {rem_in[63:0], rad_in[sdpa_pkg::RAD_W-1 -: 2]};
        trial = {2'b00, root_in, 2'b01};
        fit   = (r2 >= trial);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= fit ? r2 - trial : r2;
            root_reg <= {root_in[sdpa_pkg::ROOT_BITS-2:0], fit};
            rad_reg  <= {rad_in[sdpa_pkg::RAD_W-3:0], 2'b00};
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;

endmodule

/* src/sphere_distance_position_angle_core.sv */
// ============================================================================
// sphere_distance_position_angle_core: great-circle distance and angles
// Streams pairs of sky positions and returns the angular distance (Q2.28), the
// westward position angle and the reversed angle (Q3.28), all in radians.
// ============================================================================
//
//  Channel | Direction | tdata fields (lowest bit first)              | tuser
//  --------+-----------+----------------------------------------------+-----------
//  s_      | in        | lon_first, lat_first, lon_second, lat_second | -
//  m_      | out       | distance, west_angle, reverse_angle          | degenerate
//
//  One word is taken every cycle while the skid entry of the output buffer is empty.
//  A word passes through the two CORDIC cell rows, the 62-cell square-root row
//  and three multipliers.
//  Reset clears only the valid bits of the pipeline and the output buffer.
//  A stalled output is held in a two-entry buffer, and the whole pipeline
//  freezes only once that buffer is full.
//
module sphere_distance_position_angle_core #(
    parameter int CORDIC_STAGES = sdpa_pkg::CORDIC_STAGES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // lon_first[31:0], lat_first[61:32], lon_second[93:62], lat_second[123:94]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // distance[29:0], west_angle[60:30], reverse_angle[91:61]
    output logic [95:0]  m_tdata,
    // degenerate[0]
    output logic         m_tuser
);

    localparam int CS  = CORDIC_STAGES;
    localparam int LAT = 75 + 2 * CS + 3 * sdpa_pkg::MUL_LAT;
    localparam int RB  = sdpa_pkg::ROOT_BITS;
    localparam sdpa_pkg::q_t GAIN = sdpa_pkg::q_t'(sdpa_pkg::gain_f(CORDIC_STAGES));

    typedef sdpa_pkg::q_t q_t;
    typedef sdpa_pkg::ang_t ang_t;

    // The pipeline advances whenever the skid entry is empty.
    logic en;
    logic [LAT-1:0] vld_reg;

    // ------------------------------------------------------------------
    // Front end: capture, reduce each angle into (-pi,pi], fold to [0,pi/2].
    // Lane 0 is lat_first, lane 1 lat_second, lane 2 the longitude difference.
    // ------------------------------------------------------------------
    logic signed [31:0] l1_reg, l2_reg;
    logic signed [29:0] b1_reg, b2_reg;
    ang_t ang_reg [3];
    ang_t mag_reg [3];
    logic neg_reg [3];
    ang_t rm_reg  [3];
    logic neg4_reg [3];
    ang_t m5_reg  [3];
    logic sneg5_reg [3];
    q_t   z6_reg  [3];
    logic [11:0] rflag_reg, rflag_d;
    ang_t m_fold [3];
    logic cneg_c [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cneg_c[k] = (m5_reg[k] > sdpa_pkg::HALF_PI_F);
            m_fold[k] = cneg_c[k] ? sdpa_pkg::PI_F - m5_reg[k] : m5_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l1_reg <= s_tdata[31:0];
            b1_reg <= s_tdata[61:32];
            l2_reg <= s_tdata[93:62];
            b2_reg <= s_tdata[123:94];
            ang_reg[0] <= ang_t'(b1_reg);
            ang_reg[1] <= ang_t'(b2_reg);
            ang_reg[2] <= ang_t'(l1_reg) - ang_t'(l2_reg);
            for (int k = 0; k < 3; k++) begin
                mag_reg[k]  <= ang_reg[k][33] ? -ang_reg[k] : ang_reg[k];
                neg_reg[k]  <= ang_reg[k][33];
                // Magnitude stays below three turns, so two compares reduce it.
                if (mag_reg[k] >= sdpa_pkg::FOUR_PI_F) begin
                    rm_reg[k] <= mag_reg[k] - sdpa_pkg::FOUR_PI_F;
                end else if (mag_reg[k] >= sdpa_pkg::TWO_PI_F) begin
                    rm_reg[k] <= mag_reg[k] - sdpa_pkg::TWO_PI_F;
                end else begin
                    rm_reg[k] <= mag_reg[k];
                end
                neg4_reg[k] <= neg_reg[k];
                // Map the signed remainder into (-pi,pi] as sign and magnitude.
                if (!neg4_reg[k]) begin
                    sneg5_reg[k] <= (rm_reg[k] > sdpa_pkg::PI_F);
                    m5_reg[k]    <= (rm_reg[k] > sdpa_pkg::PI_F) ?
                                    sdpa_pkg::TWO_PI_F - rm_reg[k] : rm_reg[k];
                end else begin
                    sneg5_reg[k] <= (rm_reg[k] < sdpa_pkg::PI_F);
                    m5_reg[k]    <= (rm_reg[k] >= sdpa_pkg::PI_F) ?
                                    sdpa_pkg::TWO_PI_F - rm_reg[k] : rm_reg[k];
                end
                z6_reg[k] <= q_t'(m_fold[k]) <<< sdpa_pkg::SH;
                rflag_reg[4*k +: 4] <= {sneg5_reg[k], cneg_c[k],
                                        m_fold[k] == ang_t'(0),
                                        m_fold[k] == sdpa_pkg::HALF_PI_F};
            end
        end
    end

    // ------------------------------------------------------------------
    // Sine and cosine: three rows of rotation cells.
    // ------------------------------------------------------------------
    q_t rx_w [3][CS+1];
    q_t ry_w [3][CS+1];
    q_t rz_w [3][CS+1];

    for (genvar k = 0; k < 3; k++) begin : g_rot
        assign rx_w[k][0] = GAIN;
        assign ry_w[k][0] = '0;
        assign rz_w[k][0] = z6_reg[k];
        for (genvar i = 0; i < CS; i++) begin : g_cell
            sdpa_cordic_cell #(.STAGE(i), .VECTOR(1'b0)) u_cell (
                .aclk  (aclk),
                .en    (en),
                .x_in  (rx_w[k][i]),
                .y_in  (ry_w[k][i]),
                .z_in  (rz_w[k][i]),
                .x_out (rx_w[k][i+1]),
                .y_out (ry_w[k][i+1]),
                .z_out (rz_w[k][i+1])
            );
        end
    end

    sdpa_delay #(.W(12), .D(CS)) u_rflag_dly (
        .aclk (aclk), .en (en), .d (rflag_reg), .q (rflag_d)
    );

    // Exact values at zero and at a right angle, then the quadrant signs.
    q_t sin_reg [3];
    q_t cos_reg [3];
    q_t xr [3];
    q_t yr [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (rflag_d[4*k+1]) begin
                xr[k] = sdpa_pkg::ONE_Q;
                yr[k] = '0;
            end else if (rflag_d[4*k]) begin
                xr[k] = '0;
                yr[k] = sdpa_pkg::ONE_Q;
            end else begin
                xr[k] = rx_w[k][CS];
                yr[k] = ry_w[k][CS];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                sin_reg[k] <= rflag_d[4*k+3] ? -yr[k] : yr[k];
                cos_reg[k] <= rflag_d[4*k+2] ? -xr[k] : xr[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Products for the cosine sum and for the two angle components.
    // ------------------------------------------------------------------
    q_t pa, pb, pc, pd, pe, pf, pg, ph, cd_d;
    logic [191:0] acd_d;

    sdpa_mul u_mul_s1s2 (.aclk(aclk), .en(en), .a(sin_reg[0]), .b(sin_reg[1]), .p(pa));
    sdpa_mul u_mul_c1c2 (.aclk(aclk), .en(en), .a(cos_reg[0]), .b(cos_reg[1]), .p(pb));
    sdpa_mul u_mul_sdc2 (.aclk(aclk), .en(en), .a(sin_reg[2]), .b(cos_reg[1]), .p(pc));
    sdpa_mul u_mul_s2c1 (.aclk(aclk), .en(en), .a(sin_reg[1]), .b(cos_reg[0]), .p(pd));
    sdpa_mul u_mul_c2s1 (.aclk(aclk), .en(en), .a(cos_reg[1]), .b(sin_reg[0]), .p(pe));

    sdpa_delay #(.W(64), .D(sdpa_pkg::MUL_LAT)) u_cd_dly (
        .aclk (aclk), .en (en), .d (cos_reg[2]), .q (cd_d)
    );

    sdpa_mul u_mul_cc (.aclk(aclk), .en(en), .a(pb), .b(cd_d), .p(pf));
    sdpa_mul u_mul_cv (.aclk(aclk), .en(en), .a(pe), .b(cd_d), .p(pg));

    sdpa_delay #(.W(192), .D(sdpa_pkg::MUL_LAT)) u_acd_dly (
        .aclk (aclk), .en (en), .d ({pa, pc, pd}), .q (acd_d)
    );

    // Cosine of the distance clamped to [-1,1], plus S and C.
    q_t cc_reg, sv_reg, cv_reg, cc_sum;

    assign cc_sum = q_t'(acd_d[191:128]) + pf;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (cc_sum > sdpa_pkg::ONE_Q) begin
                cc_reg <= sdpa_pkg::ONE_Q;
            end else if (cc_sum < -sdpa_pkg::ONE_Q) begin
                cc_reg <= -sdpa_pkg::ONE_Q;
            end else begin
                cc_reg <= cc_sum;
            end
            sv_reg <= q_t'(acd_d[127:64]);
            cv_reg <= q_t'(acd_d[63:0]) - pg;
        end
    end

    sdpa_mul u_mul_sq (.aclk(aclk), .en(en), .a(cc_reg), .b(cc_reg), .p(ph));

    logic [191:0] scc_d;

    sdpa_delay #(.W(192), .D(sdpa_pkg::MUL_LAT)) u_scc_dly (
        .aclk (aclk), .en (en), .d ({cc_reg, sv_reg, cv_reg}), .q (scc_d)
    );

    // ------------------------------------------------------------------
    // Sine of the distance: floor square root of 1 - cc^2 in Q2.61, found
    // as the integer root of v * 2^61 + 2^61 - 1.
    // ------------------------------------------------------------------
    q_t   v_c;
    logic [sdpa_pkg::RAD_W-1:0] rad_reg;
    logic vz_reg, degen_reg;
    q_t   cc2_reg, sv2_reg, cv2_reg, nc_reg;

    assign v_c = sdpa_pkg::ONE_Q - ph;

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg   <= {v_c[62:0], {sdpa_pkg::QI{1'b1}}};
            vz_reg    <= (v_c <= q_t'(0));
            degen_reg <= (scc_d[127:64] == 64'd0) && (scc_d[63:0] == 64'd0);
            cc2_reg   <= q_t'(scc_d[191:128]);
            sv2_reg   <= q_t'(scc_d[127:64]);
            cv2_reg   <= q_t'(scc_d[63:0]);
            nc_reg    <= -q_t'(scc_d[63:0]);
        end
    end

    logic [65:0]                rem_w  [RB+1];
    logic [RB-1:0]              root_w [RB+1];
    logic [sdpa_pkg::RAD_W-1:0] rad_w  [RB+1];

    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign rad_w[0]  = rad_reg;

    for (genvar i = 0; i < RB; i++) begin : g_sqrt
        sdpa_sqrt_cell u_cell (
            .aclk     (aclk),
            .en       (en),
            .rem_in   (rem_w[i]),
            .root_in  (root_w[i]),
            .rad_in   (rad_w[i]),
            .rem_out  (rem_w[i+1]),
            .root_out (root_w[i+1]),
            .rad_out  (rad_w[i+1])
        );
    end

    logic [257:0] sq_side_d;

    sdpa_delay #(.W(258), .D(RB)) u_sq_dly (
        .aclk (aclk),
        .en   (en),
        .d    ({cc2_reg, sv2_reg, cv2_reg, nc_reg, vz_reg, degen_reg}),
        .q    (sq_side_d)
    );

    // ------------------------------------------------------------------
    // Arctangents: halve, move into the right half plane, then vectoring rows.
    // Lane 0 is the distance, lane 1 the west angle, lane 2 the reversed angle.
    // ------------------------------------------------------------------
    q_t   ax [3];
    q_t   ay [3];
    q_t   vx_reg [3];
    q_t   vy_reg [3];
    ang_t base_reg [3];
    logic degen_p_reg;

    always_comb begin
        ay[0] = sq_side_d[1] ? q_t'(0) : q_t'(root_w[RB]);
        ax[0] = q_t'(sq_side_d[257:194]);
        ay[1] = q_t'(sq_side_d[193:130]);
        ax[1] = q_t'(sq_side_d[129:66]);
        ay[2] = q_t'(sq_side_d[193:130]);
        ax[2] = q_t'(sq_side_d[65:2]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                if (ax[k][63]) begin
                    vx_reg[k]   <= -(ax[k] >>> 1);
                    vy_reg[k]   <= -(ay[k] >>> 1);
                    base_reg[k] <= ay[k][63] ? -sdpa_pkg::PI_F : sdpa_pkg::PI_F;
                end else begin
                    vx_reg[k]   <= ax[k] >>> 1;
                    vy_reg[k]   <= ay[k] >>> 1;
                    base_reg[k] <= '0;
                end
            end
            degen_p_reg <= sq_side_d[0];
        end
    end

    q_t vx_w [3][CS+1];
    q_t vy_w [3][CS+1];
    q_t vz_w [3][CS+1];

    for (genvar k = 0; k < 3; k++) begin : g_vec
        assign vx_w[k][0] = vx_reg[k];
        assign vy_w[k][0] = vy_reg[k];
        assign vz_w[k][0] = '0;
        for (genvar i = 0; i < CS; i++) begin : g_cell
            sdpa_cordic_cell #(.STAGE(i), .VECTOR(1'b1)) u_cell (
                .aclk  (aclk),
                .en    (en),
                .x_in  (vx_w[k][i]),
                .y_in  (vy_w[k][i]),
                .z_in  (vz_w[k][i]),
                .x_out (vx_w[k][i+1]),
                .y_out (vy_w[k][i+1]),
                .z_out (vz_w[k][i+1])
            );
        end
    end

    logic [102:0] vec_side_d;

    sdpa_delay #(.W(103), .D(CS)) u_vec_dly (
        .aclk (aclk),
        .en   (en),
        .d    ({base_reg[0], base_reg[1], base_reg[2], degen_p_reg}),
        .q    (vec_side_d)
    );

    // ------------------------------------------------------------------
    // Round half up into Qf, add the half-plane offset, then wrap and clamp.
    // ------------------------------------------------------------------
    localparam q_t RND = q_t'(64'd1 << (sdpa_pkg::SH - 1));

    q_t   zr [3];
    ang_t rnd_reg [3];
    ang_t base1_reg [3];
    logic degen1_reg;
    ang_t a2_reg [3];
    logic degen2_reg;
    logic [29:0] dist_reg;
    logic [30:0] wa_reg, ra_reg;
    logic        degen3_reg;
    ang_t wrap_c [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            zr[k] = (vz_w[k][CS] + RND) >>> sdpa_pkg::SH;
            if (a2_reg[k][33]) begin
                wrap_c[k] = a2_reg[k] + sdpa_pkg::TWO_PI_F;
            end else if (a2_reg[k] >= sdpa_pkg::TWO_PI_F) begin
                wrap_c[k] = a2_reg[k] - sdpa_pkg::TWO_PI_F;
            end else begin
                wrap_c[k] = a2_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                rnd_reg[k] <= zr[k][33:0];
                a2_reg[k]  <= rnd_reg[k] + base1_reg[k];
            end
            base1_reg[0] <= vec_side_d[102:69];
            base1_reg[1] <= vec_side_d[68:35];
            base1_reg[2] <= vec_side_d[34:1];
            degen1_reg   <= vec_side_d[0];
            degen2_reg   <= degen1_reg;
            if (a2_reg[0][33]) begin
                dist_reg <= '0;
            end else if (a2_reg[0] > sdpa_pkg::PI_F) begin
                dist_reg <= sdpa_pkg::PI_F[29:0];
            end else begin
                dist_reg <= a2_reg[0][29:0];
            end
            wa_reg     <= degen2_reg ? 31'd0 : wrap_c[1][30:0];
            ra_reg     <= degen2_reg ? 31'd0 : wrap_c[2][30:0];
            degen3_reg <= degen2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Valid chain and the two-entry output buffer.
    // ------------------------------------------------------------------
    logic        out_valid_reg, skid_valid_reg, out_user_reg, skid_user_reg;
    logic [95:0] out_data_reg, skid_data_reg;
    logic [95:0] last_data;
    logic        out_free;

    assign en        = !skid_valid_reg;
    assign s_tready  = en;
    assign out_free  = !out_valid_reg || m_tready;
    assign last_data = {4'd0, ra_reg, wa_reg, dist_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_free) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (vld_reg[LAT-1]) begin
            if (out_free) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_free) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end else if (vld_reg[LAT-1]) begin
            if (out_free) begin
                out_data_reg <= last_data;
                out_user_reg <= degen3_reg;
            end else begin
                skid_data_reg <= last_data;
                skid_user_reg <= degen3_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
